/* hw/rtl/sart_pkg.sv */
`timescale 1ns / 1ps
package sart_pkg;

   localparam int OFF_BITS        = 62;
   localparam int LEN_BITS        = 16;
   localparam int MAX_RANGES_DEF  = 8;

   // Result status codes
   typedef enum logic [1:0] {
      ST_HANDLED  = 2'd0,
      ST_BUFFERED = 2'd1,
      ST_FULL     = 2'd2,
      ST_OVERFLOW = 2'd3
   } status_type;

   typedef struct packed {
      logic [OFF_BITS-1:0] range_offset;
      logic [LEN_BITS-1:0] range_length;
      logic                range_fin;
   } req_type;

   typedef struct packed {
      logic [1:0]          status;
      logic [LEN_BITS-1:0] new_bytes;
      logic [OFF_BITS-1:0] acked_offset;
      logic                fin_acked;
   } rsp_type;

   // One stored out-of-order range, kept as [start, stop)
   typedef struct packed {
      logic                valid;
      logic [OFF_BITS-1:0] start;
      logic [OFF_BITS-1:0] stop;
      logic                fin;
   } entry_type;

   typedef enum logic [2:0] {
      CELL_HOLD,
      CELL_PULL,
      CELL_PUSH,
      CELL_LOAD,
      CELL_EXTEND
   } cell_cmd_type;

   typedef struct packed {
      cell_cmd_type cmd;
      entry_type    wdata;
   } cell_ctl_type;

   // Compare results of one cell against the item's range
   typedef struct packed {
      logic lt;
      logic cov;
      logic mrg;
      logic ext;
      logic lm;
   } cell_flag_type;

endpackage

/* hw/rtl/stream_ack_range_tracker.sv */
`timescale 1ns / 1ps
// FIN-only, overflow, covered and full items get their result from the evaluate state; an
// out-of-order item pulls the entries it merges in the delete state and is written in the
// final state; an in-order item absorbs stored entries in the absorb state. One item at a
// time: busy is high until the result strobe, and the next item can be taken in the
// strobe cycle. The rate is set by the table cells, which shift one place per cycle.
// Reset clears offset, FIN flag and table valid bits; the receiver cannot stall a result.
module stream_ack_range_tracker
   import sart_pkg::*;
#(
   parameter int MAX_RANGES = MAX_RANGES_DEF
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    start,
   output logic    busy,
   input  req_type req_data,
   output logic    rsp_valid,
   output rsp_type rsp_data
);

   localparam int CW = $clog2(MAX_RANGES + 1);

   typedef enum logic [2:0] {
      S_IDLE,
      S_EVAL,
      S_DEL,
      S_FINAL,
      S_ABSORB
   } state_type;

   state_type           state_ff, state_in;
   logic [OFF_BITS-1:0] off_ff, off_in;
   logic [LEN_BITS-1:0] len_ff, len_in;
   logic                fin_ff, fin_in;
   logic [OFF_BITS-1:0] stop_ff, stop_in;
   logic                ovf_ff, ovf_in;
   logic [OFF_BITS-1:0] contig_ff, contig_in;
   logic                fin_seen_ff, fin_seen_in;
   logic [CW-1:0]       m_ff, m_in;
   logic [CW-1:0]       k_ff, k_in;
   logic                lmerge_ff, lmerge_in;
   logic [MAX_RANGES-1:0] lm_ff, lm_in;
   logic [OFF_BITS-1:0] lstop_ff, lstop_in;
   logic [OFF_BITS-1:0] e_ff, e_in;
   logic                f_ff, f_in;
   logic [LEN_BITS-1:0] acc_ff, acc_in;
   logic                rsp_valid_ff, rsp_valid_in;
   rsp_type             rsp_ff, rsp_in;

   entry_type           q    [MAX_RANGES];
   entry_type           lft  [MAX_RANGES];
   entry_type           rgt  [MAX_RANGES];
   cell_ctl_type        ctl  [MAX_RANGES];
   cell_flag_type       flag [MAX_RANGES];
   logic [LEN_BITS-1:0] ov   [MAX_RANGES];

   logic [OFF_BITS:0]   sum;
   logic [CW-1:0]       m_cnt, k_cnt;
   logic                any_cov, any_lm, any_ext;
   logic [OFF_BITS-1:0] ext_stop, lm_stop;
   logic                ext_fin;
   logic [LEN_BITS-1:0] ov_sel;
   logic [LEN_BITS-1:0] lm_part;
   logic                absorb_hit;

   assign busy      = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // Row of table cells, each handing its entry to both neighbors
   for (genvar i = 0; i < MAX_RANGES; i++) begin : g_cell
      if (i == 0) begin : g_first
         assign lft[i] = '0;
      end else begin : g_mid
         assign lft[i] = q[i-1];
      end
      if (i == MAX_RANGES - 1) begin : g_last
         assign rgt[i] = '0;
      end else begin : g_body
         assign rgt[i] = q[i+1];
      end
      sart_cell u_cell (
         .clock    (clock),
         .reset    (reset),
         .ctl      (ctl[i]),
         .left     (lft[i]),
         .right    (rgt[i]),
         .key_off  (off_ff),
         .key_stop (stop_ff),
         .q        (q[i]),
         .flag     (flag[i]),
         .ov       (ov[i])
      );
   end

   // Reduce cell flags: insert position, merge count, extension end
   always_comb begin
      m_cnt    = '0;
      k_cnt    = '0;
      any_cov  = 1'b0;
      any_lm   = 1'b0;
      any_ext  = 1'b0;
      ext_stop = '0;
      ext_fin  = 1'b0;
      lm_stop  = '0;
      ov_sel   = '0;
      for (int i = 0; i < MAX_RANGES; i++) begin
         m_cnt   = m_cnt + CW'(flag[i].lt);
         k_cnt   = k_cnt + CW'(flag[i].mrg);
         any_cov = any_cov | flag[i].cov;
         any_lm  = any_lm | flag[i].lm;
         any_ext = any_ext | flag[i].ext;
         if (flag[i].ext) begin
            ext_stop = ext_stop | q[i].stop;
            ext_fin  = ext_fin | q[i].fin;
         end
         if (flag[i].lm) begin
            lm_stop = lm_stop | q[i].stop;
         end
         if (CW'(i) == m_ff) begin
            ov_sel = ov_sel | ov[i];
         end
      end
   end

   assign absorb_hit = q[0].valid && (q[0].start <= contig_ff);
   assign sum        = {1'b0, req_data.range_offset} + {{(OFF_BITS + 1 - LEN_BITS){1'b0}},
                                                        req_data.range_length};
   assign lm_part    = lstop_ff[LEN_BITS-1:0] - off_ff[LEN_BITS-1:0];

   // Sequencer next state
   always_comb begin
      state_in     = state_ff;
      off_in       = off_ff;
      len_in       = len_ff;
      fin_in       = fin_ff;
      stop_in      = stop_ff;
      ovf_in       = ovf_ff;
      contig_in    = contig_ff;
      fin_seen_in  = fin_seen_ff;
      m_in         = m_ff;
      k_in         = k_ff;
      lmerge_in    = lmerge_ff;
      lm_in        = lm_ff;
      lstop_in     = lstop_ff;
      e_in         = e_ff;
      f_in         = f_ff;
      acc_in       = acc_ff;
      rsp_valid_in = 1'b0;
      rsp_in       = rsp_ff;
      case (state_ff)
         S_IDLE: begin
            if (start) begin
               off_in   = req_data.range_offset;
               len_in   = req_data.range_length;
               fin_in   = req_data.range_fin;
               stop_in  = sum[OFF_BITS-1:0];
               ovf_in   = sum[OFF_BITS];
               state_in = S_EVAL;
            end
         end
         S_EVAL: begin
            rsp_in.new_bytes = '0;
            if (len_ff == '0) begin
               if (fin_ff) fin_seen_in = 1'b1;
               rsp_in.status = ST_HANDLED;
               rsp_valid_in  = 1'b1;
            end else if (ovf_ff) begin
               rsp_in.status = ST_OVERFLOW;
               rsp_valid_in  = 1'b1;
            end else if (off_ff <= contig_ff) begin
               if (stop_ff > contig_ff) begin
                  contig_in = stop_ff;
                  if (fin_ff) fin_seen_in = 1'b1;
                  state_in  = S_ABSORB;
               end else begin
                  rsp_in.status = ST_HANDLED;
                  rsp_valid_in  = 1'b1;
               end
            end else if (any_cov) begin
               rsp_in.status = ST_HANDLED;
               rsp_valid_in  = 1'b1;
            end else if (!any_lm && (k_cnt == '0) && q[MAX_RANGES-1].valid) begin
               rsp_in.status = ST_FULL;
               rsp_valid_in  = 1'b1;
            end else begin
               m_in      = m_cnt;
               k_in      = k_cnt;
               lmerge_in = any_lm;
               lstop_in  = lm_stop;
               e_in      = any_ext ? ext_stop : stop_ff;
               f_in      = any_ext ? ext_fin : fin_ff;
               acc_in    = '0;
               for (int i = 0; i < MAX_RANGES; i++) begin
                  lm_in[i] = flag[i].lm;
               end
               state_in  = (k_cnt != '0) ? S_DEL : S_FINAL;
            end
         end
         S_DEL: begin
            acc_in = acc_ff + ov_sel;
            k_in   = k_ff - CW'(1);
            if (k_ff == CW'(1)) state_in = S_FINAL;
         end
         S_FINAL: begin
            rsp_in.status    = ST_BUFFERED;
            rsp_in.new_bytes = len_ff - acc_ff - (lmerge_ff ? lm_part : '0);
            rsp_valid_in     = 1'b1;
         end
         S_ABSORB: begin
            if (absorb_hit) begin
               if (q[0].stop > contig_ff) contig_in = q[0].stop;
               if (q[0].fin) fin_seen_in = 1'b1;
            end else begin
               rsp_in.status    = ST_HANDLED;
               rsp_in.new_bytes = '0;
               rsp_valid_in     = 1'b1;
            end
         end
         default: state_in = S_IDLE;
      endcase
      if (rsp_valid_in) begin
         rsp_in.acked_offset = contig_in;
         rsp_in.fin_acked    = fin_seen_in;
         state_in            = S_IDLE;
      end
   end

   // Cell commands
   always_comb begin
      for (int i = 0; i < MAX_RANGES; i++) begin
         ctl[i].cmd         = CELL_HOLD;
         ctl[i].wdata.valid = 1'b1;
         ctl[i].wdata.start = off_ff;
         ctl[i].wdata.stop  = e_ff;
         ctl[i].wdata.fin   = f_ff;
         case (state_ff)
            S_DEL: begin
               if (CW'(i) >= m_ff) ctl[i].cmd = CELL_PULL;
            end
            S_FINAL: begin
               if (lmerge_ff) begin
                  if (lm_ff[i]) ctl[i].cmd = CELL_EXTEND;
               end else if (CW'(i) == m_ff) begin
                  ctl[i].cmd = CELL_LOAD;
               end else if (CW'(i) > m_ff) begin
                  ctl[i].cmd = CELL_PUSH;
               end
            end
            S_ABSORB: begin
               if (absorb_hit) ctl[i].cmd = CELL_PULL;
            end
            default: ctl[i].cmd = CELL_HOLD;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         contig_ff    <= '0;
         fin_seen_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         contig_ff    <= contig_in;
         fin_seen_ff  <= fin_seen_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_ff <= rsp_in;
   end

   always_ff @(posedge clock) begin
      off_ff    <= off_in;
      len_ff    <= len_in;
      fin_ff    <= fin_in;
      stop_ff   <= stop_in;
      ovf_ff    <= ovf_in;
      m_ff      <= m_in;
      k_ff      <= k_in;
      lmerge_ff <= lmerge_in;
      lm_ff     <= lm_in;
      lstop_ff  <= lstop_in;
      e_ff      <= e_in;
      f_ff      <= f_in;
      acc_ff    <= acc_in;
   end

endmodule

/* hw/rtl/sart_cell.sv */
`timescale 1ns / 1ps
module sart_cell
   import sart_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  cell_ctl_type        ctl,
   input  entry_type           left,
   input  entry_type           right,
   input  logic [OFF_BITS-1:0] key_off,
   input  logic [OFF_BITS-1:0] key_stop,
   output entry_type           q,
   output cell_flag_type       flag,
   output logic [LEN_BITS-1:0] ov
);

   entry_type           entry_ff;
   entry_type           entry_in;
   logic [OFF_BITS-1:0] lo;

   assign q = entry_ff;

   // Position of this entry relative to the item's range
   always_comb begin
      flag.lt  = entry_ff.valid && (entry_ff.start < key_off);
      flag.cov = entry_ff.valid && (entry_ff.start <= key_off) && (entry_ff.stop >= key_stop);
      flag.mrg = entry_ff.valid && (entry_ff.start >= key_off) && (entry_ff.start <= key_stop);
      flag.ext = flag.mrg && (entry_ff.stop > key_stop);
      flag.lm  = flag.lt && (entry_ff.stop >= key_off);
   end

   // Overlap with the item, only used for merged entries (never exceeds the length)
   always_comb begin
      lo = (entry_ff.stop < key_stop) ? entry_ff.stop : key_stop;
      ov = lo[LEN_BITS-1:0] - entry_ff.start[LEN_BITS-1:0];
   end

   always_comb begin
      entry_in = entry_ff;
      case (ctl.cmd)
         CELL_HOLD:   entry_in = entry_ff;
         CELL_PULL:   entry_in = right;
         CELL_PUSH:   entry_in = left;
         CELL_LOAD:   entry_in = ctl.wdata;
         CELL_EXTEND: begin
            entry_in.stop = ctl.wdata.stop;
            entry_in.fin  = ctl.wdata.fin;
         end
         default:     entry_in = entry_ff;
      endcase
   end

   // Only the valid bit is reset
   always_ff @(posedge clock) begin
      if (reset) begin
         entry_ff.valid <= 1'b0;
      end else begin
         entry_ff.valid <= entry_in.valid;
      end
      entry_ff.start <= entry_in.start;
      entry_ff.stop  <= entry_in.stop;
      entry_ff.fin   <= entry_in.fin;
   end

endmodule

/* hw/rtl/sart_checker.sv */
`timescale 1ns / 1ps
module sart_checker
   import sart_pkg::*;
(
   input logic    clock,
   input logic    reset,
   input logic    start,
   input logic    busy,
   input logic    rsp_valid,
   input rsp_type rsp_data
);

   // Taking an item makes the block busy
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      start && !busy |=> busy)
      else $error("item taken but block not busy");

   // Results are single-cycle strobes
   a_strobe: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("result strobe longer than one cycle");

   // A result frees the block
   a_rsp_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !busy)
      else $error("busy during result strobe");

   // Busy ends only with a result
   a_busy_end: assert property (@(posedge clock) disable iff (reset)
      $fell(busy) |-> rsp_valid)
      else $error("busy dropped without a result");

   // Only buffered items report new bytes
   a_newly: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_data.status != ST_BUFFERED) |-> (rsp_data.new_bytes == '0))
      else $error("new bytes on a non-buffered result");

endmodule

bind stream_ack_range_tracker sart_checker u_sart_checker (.*);
